/* rtl/polyphonic_sample_player_assert.svh */
// Assertion macros for the polyphonic sample player.
`ifndef POLYPHONIC_SAMPLE_PLAYER_ASSERT_SVH
`define POLYPHONIC_SAMPLE_PLAYER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/psp_pkg.sv */
// Shared types, codes and tables of the polyphonic sample player.
package psp_pkg;

  localparam int VOICES_DEF       = 8;
  localparam int SAMPLE_DEPTH_DEF = 65536;

  localparam int IN_W   = 56;  // input tdata width, padded to bytes
  localparam int OUT_W  = 32;
  localparam int USER_W = 2;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 40;
  localparam int POS_W  = 48;
  localparam int FRAC_W = 16;

  localparam logic [USER_W-1:0] OP_TICK     = 2'd0;
  localparam logic [USER_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [USER_W-1:0] OP_NOTE_OFF = 2'd2;
  localparam logic [USER_W-1:0] OP_LOAD     = 2'd3;

  localparam logic [CIDX_W-1:0] REG_LISTEN_CHANNEL = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MONO_MODE      = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SAMPLE_LENGTH  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_START_OFFSET   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LOOP_BEGIN     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LOOP_FINISH    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_BASE_STEP      = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_NOTE_FIN, ST_TICK, ST_DRAIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic capture_note;
    logic load;
    logic note_off;
    logic mul_lo;
    logic mul_hi;
    logic note_fin;
    logic tick_start;
    logic issue;
    logic out_load;
  } psp_cmd_t;

  typedef struct packed {
    logic chan_hit;
    logic last_voice;
    logic out_free;
  } psp_stat_t;

  // round(2^20 * 2^(r/12))
  function automatic logic [20:0] semitone(input logic [3:0] r);
    logic [20:0] t;
    case (r)
      4'd0:    t = 21'd1048576;
      4'd1:    t = 21'd1110928;
      4'd2:    t = 21'd1176987;
      4'd3:    t = 21'd1246974;
      4'd4:    t = 21'd1321124;
      4'd5:    t = 21'd1399681;
      4'd6:    t = 21'd1482910;
      4'd7:    t = 21'd1571089;
      4'd8:    t = 21'd1664511;
      4'd9:    t = 21'd1763488;
      4'd10:   t = 21'd1868350;
      4'd11:   t = 21'd1979448;
      default: t = 21'd1048576;
    endcase
    return t;
  endfunction

endpackage

/* rtl/psp_ctrl.sv */
// Sequencer for note-on, tick and output handoff.
module psp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [1:0]          in_op,
  input  psp_pkg::psp_stat_t  stat,
  output logic                in_ready,
  output psp_pkg::psp_cmd_t   cmd
);

  psp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == psp_pkg::ST_IDLE);
    case (state)
      psp_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            psp_pkg::OP_LOAD: cmd.load = 1'b1;
            psp_pkg::OP_NOTE_OFF: cmd.note_off = stat.chan_hit;
            psp_pkg::OP_NOTE_ON: begin
              if (stat.chan_hit) begin
                cmd.capture_note = 1'b1;
                state_next       = psp_pkg::ST_MUL_LO;
              end
            end
            default: begin
              cmd.tick_start = 1'b1;
              state_next     = psp_pkg::ST_TICK;
            end
          endcase
        end
      end
      psp_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = psp_pkg::ST_MUL_HI;
      end
      psp_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = psp_pkg::ST_NOTE_FIN;
      end
      psp_pkg::ST_NOTE_FIN: begin
        cmd.note_fin = 1'b1;
        state_next   = psp_pkg::ST_IDLE;
      end
      psp_pkg::ST_TICK: begin
        cmd.issue = 1'b1;
        if (stat.last_voice) state_next = psp_pkg::ST_DRAIN;
      end
      psp_pkg::ST_DRAIN: state_next = psp_pkg::ST_OUT;
      psp_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = psp_pkg::ST_IDLE;
        end
      end
      default: state_next = psp_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/psp_dp.sv */
// Datapath: config registers, sample memory, voice state, pitch and mix.
module psp_dp #(
  parameter int VOICES       = psp_pkg::VOICES_DEF,
  parameter int SAMPLE_DEPTH = psp_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [psp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [psp_pkg::CDAT_W-1:0]    cfg_data,
  input  logic [psp_pkg::IN_W-1:0]      in_data,
  input  psp_pkg::psp_cmd_t             cmd,
  input  logic                          out_ready,
  output psp_pkg::psp_stat_t            stat,
  output logic                          out_valid,
  output logic [psp_pkg::OUT_W-1:0]     out_data
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int PW = psp_pkg::POS_W;
  localparam int FW = psp_pkg::FRAC_W;
  localparam logic [PW-1:0] POS_MAX = '1;

  // input fields
  logic [3:0]  in_chan;
  logic [6:0]  in_note;
  logic [6:0]  in_vel;
  logic [15:0] in_addr;
  logic [15:0] in_value;
  assign in_chan  = in_data[3:0];
  assign in_note  = in_data[10:4];
  assign in_vel   = in_data[17:11];
  assign in_addr  = in_data[33:18];
  assign in_value = in_data[49:34];

  // config
  logic [3:0]  listen_channel;
  logic        mono_mode;
  logic [16:0] sample_length;
  logic [15:0] start_offset;
  logic [15:0] loop_begin;
  logic [16:0] loop_finish;
  logic [39:0] base_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= '0;
      mono_mode      <= 1'b0;
      sample_length  <= '0;
      start_offset   <= '0;
      loop_begin     <= '0;
      loop_finish    <= '1;
      base_step      <= 40'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        psp_pkg::REG_LISTEN_CHANNEL: listen_channel <= cfg_data[3:0];
        psp_pkg::REG_MONO_MODE:      mono_mode      <= cfg_data[0];
        psp_pkg::REG_SAMPLE_LENGTH:  sample_length  <= cfg_data[16:0];
        psp_pkg::REG_START_OFFSET:   start_offset   <= cfg_data[15:0];
        psp_pkg::REG_LOOP_BEGIN:     loop_begin     <= cfg_data[15:0];
        psp_pkg::REG_LOOP_FINISH:    loop_finish    <= cfg_data[16:0];
        psp_pkg::REG_BASE_STEP:      base_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample memory
  logic [15:0] mem [SAMPLE_DEPTH];
  logic [15:0] rd_data;

  // voice state
  logic [PW-1:0] pos   [VOICES];
  logic [PW-1:0] step  [VOICES];
  logic [6:0]    vnote [VOICES];
  logic [6:0]    vgain [VOICES];
  logic [VOICES-1:0] started;
  logic [VW-1:0] next_voice;
  logic [VW-1:0] vcnt;

  // note-on pipeline
  logic [6:0]  note_q, vel_q;
  logic [40:0] prod_lo, prod_hi;
  logic [7:0]  n_plus;
  logic [15:0] oct_mul;
  logic [3:0]  oct, rem;
  logic [20:0] tab;
  logic [60:0] prod;
  logic [60:0] shifted;
  logic [4:0]  shamt;
  logic [PW-1:0] new_step;
  logic [14:0] vel_mul;
  logic [6:0]  new_gain;
  logic [VW-1:0] tgt;

  always_comb begin
    n_plus   = {1'b0, note_q} + 8'd2;
    oct_mul  = n_plus * 8'd171;          // floor(n/12) for n <= 129
    oct      = oct_mul[14:11];
    rem      = 4'(n_plus - 8'(oct) * 8'd12);
    tab      = psp_pkg::semitone(rem);
    prod     = {20'd0, prod_lo} + {prod_hi, 20'd0};
    shamt    = 5'd20 - 5'(oct);
    shifted  = prod >> shamt;
    new_step = (|shifted[60:PW]) ? POS_MAX : shifted[PW-1:0];
    vel_mul  = vel_q * 8'd171;           // floor(vel/3) for vel <= 127
    new_gain = {vel_mul[14:9], 1'b0} + 7'd42;
    // the pending voice plays first; mono mode only pins the following ones to voice 0
    tgt      = next_voice;
  end

  // note-off search: first voice holding the note
  logic          off_hit;
  logic [VW-1:0] off_idx;
  always_comb begin
    off_hit = 1'b0;
    off_idx = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!off_hit && vnote[i] == in_note) begin
        off_hit = 1'b1;
        off_idx = VW'(i);
      end
    end
  end

  // tick: one voice per cycle
  logic [PW-1:0] cur_pos, base_pos, upd_pos;
  logic [31:0]   ipart;
  logic          active, wrap;
  logic [PW:0]   sum_pos;
  always_comb begin
    cur_pos  = pos[vcnt];
    ipart    = cur_pos[PW-1:FW];
    active   = started[vcnt] && (ipart < {15'd0, sample_length});
    wrap     = (ipart > {15'd0, loop_finish}) ||
               ((ipart == {15'd0, loop_finish}) && (|cur_pos[FW-1:0]));
    base_pos = wrap ? {16'd0, loop_begin, 16'd0} : cur_pos;
    sum_pos  = {1'b0, base_pos} + {1'b0, step[vcnt]};
    upd_pos  = sum_pos[PW] ? POS_MAX : sum_pos[PW-1:0];
  end

  logic        rd_valid;
  logic [6:0]  rd_gain;
  logic signed [23:0] scaled;
  logic signed [23:0] biased;
  logic signed [15:0] contrib;
  logic [31:0] acc;
  always_comb begin
    scaled  = $signed(rd_data) * $signed({1'b0, rd_gain});
    biased  = scaled + (scaled[23] ? 24'sd255 : 24'sd0);
    contrib = 16'(biased >>> 8);
  end

  assign stat.chan_hit   = (in_chan == listen_channel);
  assign stat.last_voice = (vcnt == VW'(VOICES - 1));
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) mem[AW'(in_addr)] <= in_value;
    rd_data <= mem[cur_pos[FW +: AW]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_note) begin
      note_q <= in_note;
      vel_q  <= in_vel;
    end
    if (cmd.mul_lo) prod_lo <= base_step[19:0] * tab;
    if (cmd.mul_hi) prod_hi <= base_step[39:20] * tab;
    rd_gain <= vgain[vcnt];
    if (cmd.out_load) out_data <= {acc[15:0], 16'd0} - acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        pos[i]   <= '0;
        step[i]  <= '0;
        vnote[i] <= '0;
        vgain[i] <= '0;
      end
      started    <= '0;
      next_voice <= '0;
      vcnt       <= '0;
      rd_valid   <= 1'b0;
      acc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.issue && active;
      if (cmd.note_fin) begin
        pos[tgt]     <= {16'd0, start_offset, 16'd0};
        vnote[tgt]   <= note_q;
        vgain[tgt]   <= new_gain;
        step[tgt]    <= new_step;
        started[tgt] <= 1'b1;
        if (mono_mode) begin
          next_voice <= '0;
        end else if (next_voice == VW'(VOICES - 1)) begin
          next_voice <= '0;
        end else begin
          next_voice <= next_voice + 1'b1;
        end
      end
      if (cmd.note_off && off_hit) begin
        pos[off_idx]   <= {15'd0, sample_length, 16'd0};
        vnote[off_idx] <= '0;
      end
      if (cmd.tick_start) begin
        vcnt <= '0;
        acc  <= '0;
      end else begin
        if (cmd.issue) begin
          vcnt <= vcnt + 1'b1;
          if (active) pos[vcnt] <= upd_pos;
        end
        if (rd_valid) acc <= acc + 32'(contrib);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/polyphonic_sample_player.sv */
// Polyphonic sampler: a tick sweeps one voice per cycle, then memory read + drain + out.
// The result of a tick is registered at the output and held until taken.
// Note-on runs capture, two 20x21 partial products, then step finish; load/note-off act from idle.
// A tick holds the input longer only while the previous result is still unread at the output.
// Sync active-high reset clears voices and control and sets config to defaults; sample memory is not cleared.
module polyphonic_sample_player #(
  parameter int VOICES       = psp_pkg::VOICES_DEF,
  parameter int SAMPLE_DEPTH = psp_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [psp_pkg::CDAT_W-1:0]    cfg_data,
  // input words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // midi_chan[3:0], note_num[10:4], velocity[17:11], load_addr[33:18], load_value[49:34]
  input  logic [psp_pkg::IN_W-1:0]      s_tdata,
  // op[1:0]
  input  logic [psp_pkg::USER_W-1:0]    s_tuser,
  // result words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // mix_out[31:0]
  output logic [psp_pkg::OUT_W-1:0]     m_tdata
);

  psp_pkg::psp_cmd_t  cmd;
  psp_pkg::psp_stat_t stat;
  logic in_fire;

  // config registers never stall
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;

  psp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_op    (s_tuser),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  psp_dp #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

`include "polyphonic_sample_player_assert.svh"

  // a new result never overwrites one still waiting
  `PSP_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
  // a taken word with nothing new behind it empties the output stage
  `PSP_ASSERT_NEXT(a_out_drains, m_tvalid && m_tready && !cmd.out_load, !m_tvalid, "stale word")
  // a tick holds off further input while the voices are swept
  `PSP_ASSERT_NEXT(a_tick_busy, in_fire && s_tuser == psp_pkg::OP_TICK, !s_tready, "tick not busy")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the polyphonic sample player: directed and random stream traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 8;
  localparam logic [63:0] POS_SAT = 64'hFFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 24;  // quiet margin after the last mix word, covering a tick sweep and a note-on

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [psp_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [psp_pkg::CDAT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [psp_pkg::IN_W-1:0] s_tdata = '0;
  logic [psp_pkg::USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [psp_pkg::OUT_W-1:0] m_tdata;

  polyphonic_sample_player dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: a mirror of the voices, the register file and the sample memory.
  logic [3:0]  chan_sel;
  logic        mono;
  logic [16:0] len_words;
  logic [15:0] start_pt;
  logic [15:0] loop_lo;
  logic [16:0] loop_hi;
  logic [39:0] base_rate;
  logic [15:0] wave_mem [65536];
  bit          wave_written [65536];
  logic [63:0] voice_pos [NV];
  logic [63:0] voice_inc [NV];
  logic [6:0]  voice_key [NV];
  logic [7:0]  voice_amp [NV];
  bit          voice_on [NV];
  int          rr_voice;

  logic [31:0] expected_mix [$];
  int errors = 0;
  int mixes_checked = 0;
  int words_sent = 0;
  int ticks_sent = 0;
  int notes_sent = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;

  // Semitone ratios in 20 fraction bits, one octave.
  function automatic logic [63:0] ratio20(input int r);
    case (r)
      0: return 64'd1048576;  1: return 64'd1110928;  2: return 64'd1176987;
      3: return 64'd1246974;  4: return 64'd1321124;  5: return 64'd1399681;
      6: return 64'd1482910;  7: return 64'd1571089;  8: return 64'd1664511;
      9: return 64'd1763488;  10: return 64'd1868350; default: return 64'd1979448;
    endcase
  endfunction

  function automatic logic [63:0] note_increment(input logic [6:0] key);
    int n;
    logic [63:0] prod;
    logic [63:0] inc;
    n = int'(key) + 2;
    prod = {24'd0, base_rate} * ratio20(n % 12);
    inc = prod >> (20 - n / 12);
    return (inc > POS_SAT) ? POS_SAT : inc;
  endfunction

  // Output of one voice for a tick; advances its position.
  function automatic int voice_output(input int v);
    logic [63:0] pos;
    int smp;
    int val;
    pos = voice_pos[v];
    if (!voice_on[v] || pos >= ({47'd0, len_words} << 16)) return 0;
    smp = int'($signed(wave_mem[pos[31:16]]));
    val = (smp * int'(voice_amp[v])) / 256;
    if (pos > ({47'd0, loop_hi} << 16)) pos = {48'd0, loop_lo} << 16;
    pos = pos + voice_inc[v];
    voice_pos[v] = (pos > POS_SAT) ? POS_SAT : pos;
    return val;
  endfunction

  function automatic void predict_word(input logic [1:0] op, input logic [3:0] ch,
                                       input logic [6:0] key, input logic [6:0] vel,
                                       input logic [15:0] addr, input logic [15:0] val);
    logic [31:0] acc;
    acc = '0;
    if (op == psp_pkg::OP_TICK) begin
      for (int v = 0; v < NV; v++) acc = acc + voice_output(v);
      expected_mix.push_back(acc * 32'hFFFF);
    end else if (op == psp_pkg::OP_LOAD) begin
      wave_mem[addr] = val;
      wave_written[addr] = 1'b1;
    end else if (ch == chan_sel) begin
      if (op == psp_pkg::OP_NOTE_ON) begin
        voice_pos[rr_voice] = {48'd0, start_pt} << 16;
        voice_key[rr_voice] = key;
        voice_amp[rr_voice] = 8'(int'(vel) / 3 * 2 + 42);
        voice_inc[rr_voice] = note_increment(key);
        voice_on[rr_voice] = 1'b1;
        rr_voice = mono ? 0 : (rr_voice + 1) % NV;
      end else begin
        for (int v = 0; v < NV; v++) begin
          if (voice_key[v] == key) begin
            voice_pos[v] = {47'd0, len_words} << 16;
            voice_key[v] = '0;
            break;
          end
        end
      end
    end
  endfunction

  function automatic int pick_gap();
    if (!gaps_on || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Result side: random backpressure, with stall-free stretches.
  initial begin
    forever begin
      @(negedge clk);
      if (!stall_on) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 14) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(6, 30)) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compare each accepted mix word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_mix.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected mix word %h", m_tdata);
      end else begin
        logic [31:0] want;
        want = expected_mix.pop_front();
        mixes_checked++;
        if (m_tdata !== want) begin
          errors++;
          if (errors <= 10) $display("tb: mix_out mismatch expected %h actual %h", want, m_tdata);
        end
      end
    end
  end

  // One input word; the predictor advances at the accepting edge.
  task automatic send_word(input logic [1:0] op, input logic [3:0] ch, input logic [6:0] key,
                           input logic [6:0] vel, input logic [15:0] addr,
                           input logic [15:0] val);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, val, addr, vel, key, ch};
    do @(posedge clk); while (!s_tready);
    predict_word(op, ch, key, vel, addr, val);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic load_word(input logic [15:0] addr, input logic [15:0] val);
    send_word(psp_pkg::OP_LOAD, 4'($urandom()), 7'($urandom()), 7'($urandom()), addr, val);
  endtask

  // A tick never reads memory that was not loaded: missing words are loaded first.
  task automatic tick();
    logic [63:0] pos;
    for (int v = 0; v < NV; v++) begin
      pos = voice_pos[v];
      if (voice_on[v] && pos < ({47'd0, len_words} << 16) && !wave_written[pos[31:16]])
        load_word(pos[31:16], 16'($urandom()));
    end
    send_word(psp_pkg::OP_TICK, 4'($urandom()), 7'($urandom()), 7'($urandom()),
              16'($urandom()), 16'($urandom()));
    ticks_sent++;
  endtask

  task automatic note_on(input logic [3:0] ch, input logic [6:0] key, input logic [6:0] vel);
    send_word(psp_pkg::OP_NOTE_ON, ch, key, vel, 16'($urandom()), 16'($urandom()));
    notes_sent++;
  endtask

  task automatic note_off(input logic [3:0] ch, input logic [6:0] key);
    send_word(psp_pkg::OP_NOTE_OFF, ch, key, 7'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  // Sender holds off until every mix word is back and the block has drained.
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_mix.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [psp_pkg::CIDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[psp_pkg::CDAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psp_pkg::REG_LISTEN_CHANNEL: chan_sel = val[3:0];
      psp_pkg::REG_MONO_MODE:      mono = val[0];
      psp_pkg::REG_SAMPLE_LENGTH:  len_words = val[16:0];
      psp_pkg::REG_START_OFFSET:   start_pt = val[15:0];
      psp_pkg::REG_LOOP_BEGIN:     loop_lo = val[15:0];
      psp_pkg::REG_LOOP_FINISH:    loop_hi = val[16:0];
      default:                     base_rate = val[39:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [3:0] ch, input bit mono_on, input logic [16:0] len,
                           input logic [15:0] st, input logic [15:0] lb,
                           input logic [16:0] lf, input logic [39:0] br);
    wait_quiet();
    write_reg(psp_pkg::REG_LISTEN_CHANNEL, 64'(ch));
    write_reg(psp_pkg::REG_MONO_MODE, 64'(mono_on));
    write_reg(psp_pkg::REG_SAMPLE_LENGTH, 64'(len));
    write_reg(psp_pkg::REG_START_OFFSET, 64'(st));
    write_reg(psp_pkg::REG_LOOP_BEGIN, 64'(lb));
    write_reg(psp_pkg::REG_LOOP_FINISH, 64'(lf));
    write_reg(psp_pkg::REG_BASE_STEP, 64'(br));
  endtask

  // Directed: field extremes, each op, foreign channel, note-off on a silent voice, note zero.
  task automatic test_directed();
    write_all(4'd0, 1'b0, 17'd16, 16'd0, 16'd2, 17'd10, 40'd65536);
    for (int a = 0; a < 12; a++) load_word(a[15:0], (a % 2) ? 16'h7FFF : 16'h8000);
    load_word(16'hFFFF, 16'h1234);
    note_off(4'd0, 7'd0);              // matches a voice never triggered
    note_on(4'd0, 7'd0, 7'd127);
    note_on(4'd0, 7'd127, 7'd0);
    note_on(4'd5, 7'd60, 7'd100);      // foreign channel, dropped
    tick();
    tick();
    note_off(4'd5, 7'd127);            // foreign channel, dropped
    note_off(4'd0, 7'd127);
    tick();
    note_off(4'd0, 7'd0);
    tick();
    tick();
  endtask

  // Random traffic mostly on the listened channel, note-offs aimed at held notes.
  task automatic random_words(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (i % 120 == 60) gaps_on = !gaps_on;
      if (sel < 40) begin
        tick();
      end else if (sel < 65) begin
        note_on(($urandom_range(0, 4) == 0) ? 4'($urandom()) : chan_sel,
                7'($urandom()), 7'($urandom()));
      end else if (sel < 80) begin
        note_off(($urandom_range(0, 5) == 0) ? 4'($urandom()) : chan_sel,
                 ($urandom_range(0, 2) != 0) ? voice_key[$urandom_range(0, NV - 1)]
                                             : 7'($urandom()));
      end else begin
        load_word(($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom()),
                  16'($urandom()));
      end
    end
  endtask

  // Register extremes, then random settings; each phase ends with the sender paused.
  task automatic test_settings();
    write_all(4'd0, 1'b0, 17'd0, 16'd0, 16'd0, 17'd0, 40'd0);
    random_words(60);
    write_all(4'd15, 1'b1, 17'd65536, 16'd65535, 16'd65535, 17'd131071, 40'hFF_FFFF_FFFF);
    random_words(60);
    for (int p = 0; p < 8; p++) begin
      write_all(4'($urandom()), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 17'd65536 : 17'($urandom_range(1, 200)),
                16'($urandom_range(0, 150)), 16'($urandom_range(0, 100)),
                ($urandom_range(0, 3) == 0) ? 17'd131071 : 17'($urandom_range(0, 200)),
                ($urandom_range(0, 3) == 0) ? 40'($urandom()) << $urandom_range(0, 8)
                                            : 40'($urandom_range(0, 40000)));
      stall_on = (p != 3);
      random_words(70);
    end
    stall_on = 1'b1;
  endtask

  initial begin
    chan_sel = '0;
    mono = 1'b0;
    len_words = '0;
    start_pt = '0;
    loop_lo = '0;
    loop_hi = 17'd131071;
    base_rate = 40'd65536;
    rr_voice = 0;
    for (int v = 0; v < NV; v++) begin
      voice_pos[v] = '0;
      voice_inc[v] = '0;
      voice_key[v] = '0;
      voice_amp[v] = '0;
      voice_on[v] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_settings();
    wait_quiet();
    $display("tb: %0d words sent (%0d ticks, %0d note-ons), %0d mix words checked",
             words_sent, ticks_sent, notes_sent, mixes_checked);
    $display("tb: covered register extremes, mono and rotating voices, loops and stalls");
    if (errors == 0 && expected_mix.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
